/* sv/nlms_pkg.sv */
// ----------------------------------------------------------------------------
// nlms_pkg: shared constants, types and helpers
// Widths, register indexes, memory request/response structs and saturation
// functions for the leaky NLMS noise canceller.
// ----------------------------------------------------------------------------
package nlms_pkg;

  localparam int TAPS     = 32;
  localparam int TAPS_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int SAMPLE_W = 16;
  localparam int WEIGHT_W = 32;
  localparam int STEP_W   = 15;
  localparam int LEAK_W   = 15;
  localparam int REG_W    = 31;
  localparam int FRAC     = 15;

  localparam int PROD_W = WEIGHT_W + SAMPLE_W;
  localparam int ACC_W  = PROD_W + TAPS_W;
  localparam int SQ_W   = 2 * SAMPLE_W - 1;
  localparam int POW_W  = SQ_W + TAPS_W;
  localparam int DEN_W  = POW_W + 1;
  localparam int Y_W    = ACC_W - FRAC + 1;
  localparam int SE_W   = STEP_W + 1 + WEIGHT_W;
  localparam int NUM_W  = SE_W + SAMPLE_W;
  localparam int QUO_W  = NUM_W - 1;
  localparam int LKP_W  = WEIGHT_W + LEAK_W + 1;

  localparam int DIV_CNT_W = $clog2(QUO_W + 1);

  localparam int S16_MAX = 32767;
  localparam int S16_MIN = -32768;
  localparam int S32_MAX = 2147483647;
  localparam int S32_MIN = -S32_MAX - 1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAK_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGULARIZER = 2'd2;

  localparam logic [STEP_W-1:0] STEP_RESET = 15'd3277;
  localparam logic [LEAK_W-1:0] LEAK_RESET = 15'd1;
  localparam logic [REG_W-1:0]  REG_RESET  = 31'd1000;

  typedef struct packed {
    logic                       ring_we;
    logic [TAPS_W-1:0]          ring_waddr;
    logic signed [SAMPLE_W-1:0] ring_wdata;
    logic [TAPS_W-1:0]          ring_raddr;
    logic                       wt_we;
    logic [TAPS_W-1:0]          wt_waddr;
    logic signed [WEIGHT_W-1:0] wt_wdata;
    logic [TAPS_W-1:0]          wt_raddr;
  } mem_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] ring_rdata;
    logic signed [WEIGHT_W-1:0] wt_rdata;
  } mem_rsp_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [Y_W-1:0] y);
    logic signed [SAMPLE_W-1:0] r;
    if (y > S16_MAX) r = 16'sh7FFF;
    else if (y < S16_MIN) r = 16'sh8000;
    else r = y[SAMPLE_W-1:0];
    return r;
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] sat32(input logic signed [Y_W-1:0] y);
    logic signed [WEIGHT_W-1:0] r;
    if (y > S32_MAX) r = 32'sh7FFFFFFF;
    else if (y < S32_MIN) r = 32'sh80000000;
    else r = y[WEIGHT_W-1:0];
    return r;
  endfunction

endpackage

/* sv/nlms_mem.sv */
// ----------------------------------------------------------------------------
// nlms_mem: reference ring and weight memories
// Two synchronous RAMs with registered read data; per-entry valid bits make
// never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
module nlms_mem (
  input  logic               clk,
  input  logic               rst,
  input  nlms_pkg::mem_req_t req,
  output nlms_pkg::mem_rsp_t rsp
);

  logic signed [nlms_pkg::SAMPLE_W-1:0] ring_mem [nlms_pkg::TAPS];
  logic signed [nlms_pkg::WEIGHT_W-1:0] wt_mem   [nlms_pkg::TAPS];
  logic [nlms_pkg::TAPS-1:0]            ring_vld;
  logic [nlms_pkg::TAPS-1:0]            wt_vld;
  logic signed [nlms_pkg::SAMPLE_W-1:0] ring_q;
  logic signed [nlms_pkg::WEIGHT_W-1:0] wt_q;
  logic                                 ring_q_vld;
  logic                                 wt_q_vld;

  always_ff @(posedge clk) begin
    if (req.ring_we) begin
      ring_mem[req.ring_waddr] <= req.ring_wdata;
    end
    if (req.wt_we) begin
      wt_mem[req.wt_waddr] <= req.wt_wdata;
    end
    ring_q <= ring_mem[req.ring_raddr];
    wt_q   <= wt_mem[req.wt_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld   <= '0;
      wt_vld     <= '0;
      ring_q_vld <= 1'b0;
      wt_q_vld   <= 1'b0;
    end else begin
      if (req.ring_we) begin
        ring_vld[req.ring_waddr] <= 1'b1;
      end
      if (req.wt_we) begin
        wt_vld[req.wt_waddr] <= 1'b1;
      end
      ring_q_vld <= ring_vld[req.ring_raddr];
      wt_q_vld   <= wt_vld[req.wt_raddr];
    end
  end

  assign rsp.ring_rdata = ring_q_vld ? ring_q : '0;
  assign rsp.wt_rdata   = wt_q_vld ? wt_q : '0;

endmodule

/* sv/nlms_div.sv */
// ----------------------------------------------------------------------------
// nlms_div: serial unsigned divider
// Restoring division, one quotient bit per cycle; done pulses when finished.
// ----------------------------------------------------------------------------
module nlms_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [nlms_pkg::QUO_W-1:0]    dividend,
  input  logic [nlms_pkg::DEN_W-1:0]    divisor,
  output logic                          done,
  output logic [nlms_pkg::QUO_W-1:0]    quotient
);

  logic [nlms_pkg::DEN_W-1:0]     dvs;
  logic [nlms_pkg::DEN_W-1:0]     rem;
  logic [nlms_pkg::QUO_W-1:0]     quo;
  logic [nlms_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic [nlms_pkg::DEN_W:0]       rem_sh;
  logic [nlms_pkg::DEN_W:0]       diff;
  logic                           ge;

  always_comb begin
    rem_sh = {rem, quo[nlms_pkg::QUO_W-1]};
    diff   = rem_sh - {1'b0, dvs};
    ge     = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[nlms_pkg::DEN_W-1:0] : rem_sh[nlms_pkg::DEN_W-1:0];
      quo <= {quo[nlms_pkg::QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= nlms_pkg::DIV_CNT_W'(nlms_pkg::QUO_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == nlms_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

/* sv/nlms_noise_canceller.sv */
// ----------------------------------------------------------------------------
// nlms_noise_canceller: leaky NLMS adaptive noise canceller
// Sequencer around the ring/weight memories and a serial divider.
// ----------------------------------------------------------------------------
// One request at a time. A request writes its reference sample into a
// 32-entry ring, then the filter pass walks the taps (read, multiply,
// accumulate for each tap), after which cleaned_sample is loaded into the
// output register. With adapt set (and a nonzero denominator) each weight
// is then updated through read, multiply, a serial divide, leak and
// write-back. The serial divider sets the rate. Ring and weights read as
// zero after reset through per-entry valid bits, so there is no clearing
// pass. Configure only while idle.
module nlms_noise_canceller (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [nlms_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nlms_pkg::REG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [nlms_pkg::SAMPLE_W-1:0] primary_sample,
  input  logic signed [nlms_pkg::SAMPLE_W-1:0] reference_sample,
  input  logic                                 adapt,
  input  logic                                 last_in_block,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [nlms_pkg::SAMPLE_W-1:0] cleaned_sample,
  output logic                                 last_out
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_F_RD   = 12'b000000000010,
    S_F_MUL  = 12'b000000000100,
    S_F_ACC  = 12'b000000001000,
    S_RESULT = 12'b000000010000,
    S_A_PREP = 12'b000000100000,
    S_A_RD   = 12'b000001000000,
    S_A_MUL  = 12'b000010000000,
    S_A_GO   = 12'b000100000000,
    S_A_DIV  = 12'b001000000000,
    S_A_LEAK = 12'b010000000000,
    S_A_WR   = 12'b100000000000
  } state_t;

  state_t state, state_next;

  // configuration
  logic [nlms_pkg::STEP_W-1:0] step_size;
  logic [nlms_pkg::LEAK_W-1:0] leak_factor;
  logic [nlms_pkg::REG_W-1:0]  regularizer;

  // per-request registers
  logic [nlms_pkg::TAPS_W-1:0]          wi;
  logic [nlms_pkg::TAPS_W-1:0]          k;
  logic signed [nlms_pkg::SAMPLE_W-1:0] primary;
  logic                                 adapt_q;
  logic                                 last_q;
  logic signed [nlms_pkg::PROD_W-1:0]   prod;
  logic [nlms_pkg::SQ_W-1:0]            sq;
  logic signed [nlms_pkg::ACC_W-1:0]    acc;
  logic [nlms_pkg::POW_W-1:0]           pow;
  logic signed [nlms_pkg::WEIGHT_W-1:0] e_q;
  logic [nlms_pkg::DEN_W-1:0]           den;
  logic signed [nlms_pkg::SE_W-1:0]     se;
  logic signed [nlms_pkg::NUM_W-1:0]    num;
  logic signed [nlms_pkg::WEIGHT_W-1:0] wcur;
  logic signed [nlms_pkg::LKP_W-1:0]    lkp;

  logic                                 accept;
  logic                                 out_free;
  logic                                 last_tap;
  logic [nlms_pkg::TAPS_W:0]            lag_wrap;
  logic [nlms_pkg::TAPS_W-1:0]          lag_idx;
  logic [nlms_pkg::TAPS_W-1:0]          wi_inc;
  logic signed [nlms_pkg::Y_W-1:0]      y;
  logic signed [2*nlms_pkg::SAMPLE_W-1:0] sq_full;
  logic [nlms_pkg::NUM_W-1:0]           num_abs;
  logic [nlms_pkg::WEIGHT_W-1:0]        upd;
  logic                                 div_done;
  logic [nlms_pkg::QUO_W-1:0]           div_quo;

  nlms_pkg::mem_req_t mreq;
  nlms_pkg::mem_rsp_t mrsp;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign last_tap = (k == nlms_pkg::TAPS_W'(nlms_pkg::TAPS - 1));

  // ring entry of lag k: newest sample sits at wi
  always_comb begin
    lag_wrap = {1'b0, wi} + (nlms_pkg::TAPS_W + 1)'(nlms_pkg::TAPS) - {1'b0, k};
    lag_idx  = (k > wi) ? lag_wrap[nlms_pkg::TAPS_W-1:0] : wi - k;
    wi_inc   = (wi == nlms_pkg::TAPS_W'(nlms_pkg::TAPS - 1)) ? '0 : wi + 1'b1;
  end

  // error: primary minus floor(acc / 2^15), full width
  assign y = nlms_pkg::Y_W'(primary)
           - nlms_pkg::Y_W'($signed(acc[nlms_pkg::ACC_W-1:nlms_pkg::FRAC]));

  assign sq_full = mrsp.ring_rdata * mrsp.ring_rdata;
  assign num_abs = num[nlms_pkg::NUM_W-1] ? -num : num;
  assign upd     = num[nlms_pkg::NUM_W-1] ? -div_quo[nlms_pkg::WEIGHT_W-1:0]
                                          : div_quo[nlms_pkg::WEIGHT_W-1:0];

  always_comb begin
    mreq            = '0;
    mreq.ring_we    = accept;
    mreq.ring_waddr = wi;
    mreq.ring_wdata = reference_sample;
    mreq.ring_raddr = lag_idx;
    mreq.wt_raddr   = k;
    mreq.wt_we      = (state == S_A_WR);
    mreq.wt_waddr   = k;
    mreq.wt_wdata   = wcur - $signed(lkp[nlms_pkg::WEIGHT_W+nlms_pkg::FRAC-1:nlms_pkg::FRAC]);
  end

  nlms_mem u_mem (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  nlms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_A_GO),
    .dividend (num_abs[nlms_pkg::QUO_W-1:0]),
    .divisor  (den),
    .done     (div_done),
    .quotient (div_quo)
  );

  // configuration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size   <= nlms_pkg::STEP_RESET;
      leak_factor <= nlms_pkg::LEAK_RESET;
      regularizer <= nlms_pkg::REG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        nlms_pkg::CFG_STEP_SIZE:   step_size   <= cfg_data[nlms_pkg::STEP_W-1:0];
        nlms_pkg::CFG_LEAK_FACTOR: leak_factor <= cfg_data[nlms_pkg::LEAK_W-1:0];
        nlms_pkg::CFG_REGULARIZER: regularizer <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_F_RD;
      S_F_RD:   state_next = S_F_MUL;
      S_F_MUL:  state_next = S_F_ACC;
      S_F_ACC:  state_next = last_tap ? S_RESULT : S_F_RD;
      S_RESULT: if (out_free) state_next = adapt_q ? S_A_PREP : S_IDLE;
      S_A_PREP: state_next = (den == '0) ? S_IDLE : S_A_RD;
      S_A_RD:   state_next = S_A_MUL;
      S_A_MUL:  state_next = S_A_GO;
      S_A_GO:   state_next = S_A_DIV;
      S_A_DIV:  if (div_done) state_next = S_A_LEAK;
      S_A_LEAK: state_next = S_A_WR;
      S_A_WR:   state_next = last_tap ? S_IDLE : S_A_RD;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wi    <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        k <= '0;
      end else if ((state == S_F_ACC) || (state == S_A_WR)) begin
        k <= last_tap ? '0 : k + 1'b1;
      end
      // advance the ring write pointer once the request is finished
      if ((state == S_RESULT && out_free && !adapt_q)
          || (state == S_A_PREP && den == '0)
          || (state == S_A_WR && last_tap)) begin
        wi <= wi_inc;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      primary <= primary_sample;
      adapt_q <= adapt;
      last_q  <= last_in_block;
      acc     <= '0;
      pow     <= '0;
    end
    if (state == S_F_MUL) begin
      prod <= mrsp.wt_rdata * mrsp.ring_rdata;
      sq   <= sq_full[nlms_pkg::SQ_W-1:0];
    end
    if (state == S_F_ACC) begin
      acc <= acc + nlms_pkg::ACC_W'(prod);
      pow <= pow + nlms_pkg::POW_W'(sq);
    end
    if (state == S_RESULT) begin
      e_q <= nlms_pkg::sat32(y);
      den <= nlms_pkg::DEN_W'(pow) + nlms_pkg::DEN_W'(regularizer);
    end
    if (state == S_A_PREP) begin
      se <= $signed({1'b0, step_size}) * e_q;
    end
    if (state == S_A_MUL) begin
      num  <= se * mrsp.ring_rdata;
      wcur <= mrsp.wt_rdata;
    end
    if (state == S_A_DIV && div_done) begin
      wcur <= wcur + $signed(upd);
    end
    if (state == S_A_LEAK) begin
      lkp <= wcur * $signed({1'b0, leak_factor});
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESULT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && out_free) begin
      cleaned_sample <= nlms_pkg::sat16(y);
      last_out       <= last_q;
    end
  end

endmodule
